// ----- hw/rtl/dqe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// Holds the cell operation codes and the control bundles that the top level
// broadcasts to the row of storage cells. No dependencies.
package dqe_pkg;

    // Default number of storage cells in the row
    localparam int DEPTH_DEFAULT = 16;

    // Most words listed by one dump
    localparam int RESULT_LIMIT = 16;

    // Width of one stored word
    localparam int WORD_W = 32;

    // What every cell does on each clock edge
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,   // keep the stored word
        CELL_SHR  = 3'd1,   // take the word of the cell toward the front
        CELL_SHL  = 3'd2,   // take the word of the cell toward the back
        CELL_PUT  = 3'd3,   // store the pushed word if this cell is the slot after the back
        CELL_ROT  = 3'd4    // shift toward the front, back cell takes the old front word
    } cell_op_t;

    // Broadcast to every cell
    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   value;
        logic [WORD_W-1:0]   front_word;
    } cell_ctrl_t;

    // Position flags for one cell, derived from the fill count
    typedef struct packed {
        logic at_count;     // first cell past the back
        logic at_back;      // cell that holds the back word
    } cell_pos_t;

endpackage

// ----- hw/rtl/dqe_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the queue row: a word register and its next-value select.
// Depends on dqe_pkg for the control bundles.
module dqe_cell
(
    input  logic                           clk,
    input  dqe_pkg::cell_ctrl_t            ctrl,
    input  dqe_pkg::cell_pos_t             pos,
    input  logic [dqe_pkg::WORD_W-1:0]     front_side_word,
    input  logic [dqe_pkg::WORD_W-1:0]     back_side_word,
    output logic [dqe_pkg::WORD_W-1:0]     cell_word,
    output logic [dqe_pkg::WORD_W-1:0]     back_tap
);

    logic [dqe_pkg::WORD_W-1:0] word_reg;
    logic [dqe_pkg::WORD_W-1:0] word_next;

    // Select the next stored word
    always_comb
    begin
        word_next = word_reg;
        unique case (ctrl.op)
            dqe_pkg::CELL_HOLD: word_next = word_reg;
            dqe_pkg::CELL_SHR:  word_next = front_side_word;
            dqe_pkg::CELL_SHL:  word_next = back_side_word;
            dqe_pkg::CELL_PUT:
            begin
                if (pos.at_count)
                begin
                    word_next = ctrl.value;
                end
            end
            dqe_pkg::CELL_ROT:  word_next = pos.at_back ? ctrl.front_word : back_side_word;
            default:            word_next = word_reg;
        endcase
    end

    // Hold the word; contents stay undefined until written
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign cell_word = word_reg;

    // Drive the word onto the back-read bus only from the back cell
    assign back_tap = pos.at_back ? word_reg : '0;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit words held in a row of shifting cells.
// Push and pop: one item per cycle unless stalled; result registered next cycle.
// Dump: the row rotates once per stored word, listing one word per step up to the limit;
// a step per cycle while the output is free; input is stalled until the row is back.
// Reset clears the fill count, the controller and the output valid; cells are not cleared.
// Depends on dqe_pkg and dqe_cell.
module double_ended_queue
#(
    parameter int DEPTH = dqe_pkg::DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] word,
    output logic               last,
    output logic [4:0]         occupancy
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int LIST_MAX = (DEPTH < dqe_pkg::RESULT_LIMIT) ? DEPTH : dqe_pkg::RESULT_LIMIT;
    localparam int W        = dqe_pkg::WORD_W;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } cmd_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    dump_cnt_reg, dump_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [W-1:0]        word_reg, word_next;
    logic                last_reg, last_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;

    dqe_pkg::cell_ctrl_t ctrl;
    dqe_pkg::cell_pos_t  pos [DEPTH];
    logic [W-1:0]        cell_words [DEPTH];
    logic [W-1:0]        back_taps [DEPTH];
    logic [W-1:0][DEPTH-1:0] tap_cols;
    logic [W-1:0]        back_word;
    logic [CNT_W-1:0]    list_n;
    logic                out_free;
    logic                accept;

    // Row of storage cells; front word sits in cell zero
    genvar gi, gb;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [W-1:0] front_side;
            logic [W-1:0] back_side;

            if (gi == 0)
            begin : g_first
                assign front_side = ctrl.value;
            end
            else
            begin : g_mid
                assign front_side = cell_words[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign back_side = cell_words[gi];
            end
            else
            begin : g_inner
                assign back_side = cell_words[gi+1];
            end

            assign pos[gi].at_count = (count_reg == CNT_W'(gi));
            assign pos[gi].at_back  = (count_reg == CNT_W'(gi + 1));

            dqe_cell u_cell
            (
                .clk             (clk),
                .ctrl            (ctrl),
                .pos             (pos[gi]),
                .front_side_word (front_side),
                .back_side_word  (back_side),
                .cell_word       (cell_words[gi]),
                .back_tap        (back_taps[gi])
            );

            for (gb = 0; gb < W; gb++)
            begin : g_col
                assign tap_cols[gb][gi] = back_taps[gi][gb];
            end
        end

        // Collect the back word, bit by bit, from the one active tap
        for (gb = 0; gb < W; gb++)
        begin : g_back
            assign back_word[gb] = |tap_cols[gb];
        end
    endgenerate

    assign list_n   = (count_reg > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : count_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    // Decode commands and sequence the dump
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dump_cnt_next   = dump_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        word_next       = word_reg;
        last_next       = last_reg;
        occ_next        = occ_reg;
        ctrl.op         = dqe_pkg::CELL_HOLD;
        ctrl.value      = value;
        ctrl.front_word = cell_words[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            word_next      = '0;
                            last_next      = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                                occ_next    = count_reg;
                            end
                            else
                            begin
                                ctrl.op     = (command == CMD_PUSH_FRONT) ?
                                              dqe_pkg::CELL_SHR : dqe_pkg::CELL_PUT;
                                count_next  = count_reg + 1'b1;
                                status_next = STATUS_OK;
                                occ_next    = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                word_next   = '0;
                                occ_next    = count_reg;
                            end
                            else
                            begin
                                if (command == CMD_POP_FRONT)
                                begin
                                    ctrl.op   = dqe_pkg::CELL_SHL;
                                    word_next = cell_words[0];
                                end
                                else
                                begin
                                    word_next = back_word;
                                end
                                count_next  = count_reg - 1'b1;
                                status_next = STATUS_OK;
                                occ_next    = count_reg - 1'b1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STATUS_EMPTY;
                                word_next      = '0;
                                last_next      = 1'b1;
                                occ_next       = count_reg;
                            end
                            else
                            begin
                                state_next    = S_DUMP;
                                dump_cnt_next = '0;
                            end
                        end
                        default:
                        begin
                            // Drop unused codes without a result
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // List the front word and rotate, or rotate silently past the limit
                if (dump_cnt_reg >= list_n || out_free)
                begin
                    ctrl.op = dqe_pkg::CELL_ROT;
                    if (dump_cnt_reg < list_n)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_OK;
                        word_next      = cell_words[0];
                        last_next      = ((dump_cnt_reg + 1'b1) == list_n);
                        occ_next       = count_reg;
                    end
                    if (dump_cnt_reg == count_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dump_cnt_next = dump_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_cnt_reg  <= dump_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
        occ_reg    <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign word      = word_reg;
    assign last      = last_reg;
    assign occupancy = 5'(occ_reg);

`ifndef SYNTHESIS
    // Fill count never passes the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // A refused push leaves the fill count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK)
         && count_reg == CNT_W'(DEPTH)) |=> $stable(count_reg))
        else $error("refused push changed fill count");

    // A pop on a non-empty queue removes exactly one word
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_POP_FRONT || command == CMD_POP_BACK)
         && count_reg != '0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not remove one word");

    // A dump keeps the fill count
    a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(count_reg))
        else $error("fill count moved during dump");
`endif

endmodule
